// ===== hw/rtl/chained_hash_table_assert.svh =====
// ----------------------------------------------------------------------------
// chained_hash_table_assert
// Assertion macros used by the hash table controller (cht_ctrl).
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_TABLE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CHT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hash table check failed");

// next-cycle implication, checked outside reset
`define CHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hash table check failed");

`endif

// ===== hw/rtl/cht_pkg.sv =====
// ----------------------------------------------------------------------------
// cht_pkg
// Request and status codes plus controller/datapath command and status types.
// ----------------------------------------------------------------------------
package cht_pkg;

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NO_SPACE  = 2'd2;

    // smallest bucket_bits value in use
    localparam logic [3:0] BITS_MIN = 4'd3;

    // controller to datapath
    typedef struct packed {
        logic       idle;
        logic       accept;
        logic       insert;
        logic       walk_head;
        logic       walk_next;
        logic       unlink;
        logic       set_res;
        logic [1:0] res_status;
        logic       res_found;
        logic       clear_step;
        logic       load_out;
    } cht_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic       in_valid;
        logic       cfg_wr;
        logic [1:0] req_type;
        logic       pool_empty;
        logic       head_empty;
        logic       key_match;
        logic       next_empty;
        logic       clr_last;
        logic       out_busy;
    } cht_sts_t;

endpackage

// ===== hw/rtl/cht_if.sv =====
// ----------------------------------------------------------------------------
// cht_if
// Valid/ready channels for requests, results and the bucket_bits register.
// ----------------------------------------------------------------------------
interface cht_req_if #(
    parameter int KW = 32,
    parameter int VW = 32
) ();
    logic          valid;
    logic          ready;
    logic [1:0]    req_type;
    logic [KW-1:0] key;
    logic [VW-1:0] value;

    modport source (output valid, req_type, key, value, input ready);
    modport sink   (input valid, req_type, key, value, output ready);
endinterface

interface cht_rsp_if #(
    parameter int VW = 32,
    parameter int CW = 9
) ();
    logic          valid;
    logic          ready;
    logic [1:0]    status;
    logic [VW-1:0] found_value;
    logic [CW-1:0] entry_count;

    modport source (output valid, status, found_value, entry_count, input ready);
    modport sink   (input valid, status, found_value, entry_count, output ready);
endinterface

interface cht_cfg_if ();
    logic       valid;
    logic       ready;
    logic [3:0] bucket_bits;

    modport source (output valid, bucket_bits, input ready);
    modport sink   (input valid, bucket_bits, output ready);
endinterface

// ===== hw/rtl/cht_ctrl.sv =====
// ----------------------------------------------------------------------------
// cht_ctrl
// Sequencer for insert, chain walk, clearing sweep and result hand-off.
// ----------------------------------------------------------------------------
module cht_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  cht_pkg::cht_sts_t sts,
    output cht_pkg::cht_cmd_t cmd
);
    import cht_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_DISP = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (sts.in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                cmd.set_res = 1'b1;
                state_next  = S_FIN;
                unique case (sts.req_type) inside
                    REQ_INSERT:
                    begin
                        if (sts.pool_empty)
                        begin
                            cmd.res_status = ST_NO_SPACE;
                        end
                        else
                        begin
                            cmd.insert     = 1'b1;
                            cmd.res_status = ST_OK;
                        end
                    end
                    REQ_DELETE, REQ_LOOKUP:
                    begin
                        if (sts.head_empty)
                        begin
                            cmd.res_status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            cmd.set_res   = 1'b0;
                            cmd.walk_head = 1'b1;
                            state_next    = S_CMP;
                        end
                    end
                    default:
                    begin
                        cmd.res_status = ST_NOT_FOUND;
                    end
                endcase
            end
            S_CMP:
            begin
                if (sts.key_match)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_OK;
                    cmd.res_found  = (sts.req_type == REQ_LOOKUP);
                    cmd.unlink     = (sts.req_type == REQ_DELETE);
                    state_next     = S_FIN;
                end
                else if (sts.next_empty)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = ST_NOT_FOUND;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.walk_next = 1'b1;
                end
            end
            S_FIN:
            begin
                if (!sts.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLR;
            end
        endcase
        // a register write empties the table
        if (sts.cfg_wr)
        begin
            state_next = S_CLR;
        end
    end

`include "chained_hash_table_assert.svh"

    `CHT_ASSERT_NOW(a_load_free, cmd.load_out, !sts.out_busy)
    `CHT_ASSERT_NEXT(a_cfg_clears, sts.cfg_wr, state_reg == S_CLR)
    `CHT_ASSERT_NEXT(a_walk_stays, cmd.walk_next && !sts.cfg_wr, state_reg == S_CMP)
    `CHT_ASSERT_NOW(a_one_write, cmd.insert, !cmd.unlink && !cmd.clear_step)

endmodule

// ===== hw/rtl/cht_dpath.sv =====
// ----------------------------------------------------------------------------
// cht_dpath
// Bucket heads, node store, free stack, counters and the result register.
// ----------------------------------------------------------------------------
module cht_dpath #(
    parameter int MAX_BUCKETS = 256,
    parameter int NODE_POOL   = 256,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    cht_req_if.sink           req,
    cht_rsp_if.source         rsp,
    cht_cfg_if.sink           cfg,
    input  cht_pkg::cht_cmd_t cmd,
    output cht_pkg::cht_sts_t sts
);
    import cht_pkg::*;

    localparam int BW    = $clog2(MAX_BUCKETS);
    localparam int NIW   = $clog2(NODE_POOL);
    localparam int PW    = NIW + 1;
    localparam int CNTW  = $clog2(NODE_POOL + 1);
    localparam int CLR_N = (MAX_BUCKETS > NODE_POOL) ? MAX_BUCKETS : NODE_POOL;
    localparam int CLRW  = $clog2(CLR_N);
    localparam logic [PW-1:0]   NO_NODE  = PW'(NODE_POOL);
    localparam logic [3:0]      BITS_MAX = 4'(BW);
    localparam logic [CNTW-1:0] POOL_CNT = CNTW'(NODE_POOL);

    // storage
    logic [PW-1:0]          bh_mem [MAX_BUCKETS];
    logic [NIW-1:0]         fs_mem [NODE_POOL];
    logic [KEY_WIDTH-1:0]   nk_mem [NODE_POOL];
    logic [VALUE_WIDTH-1:0] nv_mem [NODE_POOL];
    logic [PW-1:0]          nn_mem [NODE_POOL];

    logic [PW-1:0]          bh_rdata;
    logic [NIW-1:0]         fs_rdata;
    logic [KEY_WIDTH-1:0]   nk_rdata;
    logic [VALUE_WIDTH-1:0] nv_rdata;
    logic [PW-1:0]          nn_rdata;

    logic [3:0]             bits_reg;
    logic [CNTW-1:0]        free_count_reg;
    logic [CNTW-1:0]        stored_reg;
    logic [CLRW-1:0]        clr_reg;
    logic [1:0]             req_type_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [BW-1:0]          bkt_reg;
    logic [PW-1:0]          cur_reg;
    logic [PW-1:0]          prev_reg;
    logic [1:0]             res_status_reg;
    logic [VALUE_WIDTH-1:0] res_value_reg;
    logic                   out_valid_reg;
    logic [1:0]             out_status_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic [CNTW-1:0]        out_count_reg;

    logic [KEY_WIDTH-1:0]   hash;
    logic [BW:0]            mask_w;
    logic [BW-1:0]          bkt_in;
    logic [CNTW-1:0]        fs_top;
    logic [NIW-1:0]         node_raddr;
    logic [3:0]             bits_in;

    // bucket hash, masked to the buckets in use
    assign hash   = req.key ^ (req.key >> 2) ^ (req.key >> 6);
    assign mask_w = ((BW+1)'(1) << bits_reg) - (BW+1)'(1);
    assign bkt_in = hash[BW-1:0] & mask_w[BW-1:0];
    assign fs_top = free_count_reg - CNTW'(1);
    assign node_raddr = cmd.walk_head ? bh_rdata[NIW-1:0] : nn_rdata[NIW-1:0];

    // saturate the written bucket_bits
    always_comb
    begin
        bits_in = cfg.bucket_bits;
        if (cfg.bucket_bits < BITS_MIN)
        begin
            bits_in = BITS_MIN;
        end
        else if (cfg.bucket_bits > BITS_MAX)
        begin
            bits_in = BITS_MAX;
        end
    end

    // bucket head and free stack reads at accept
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            bh_rdata <= bh_mem[bkt_in];
            fs_rdata <= fs_mem[fs_top[NIW-1:0]];
        end
    end

    // node reads during the chain walk
    always_ff @(posedge clk)
    begin
        if (cmd.walk_head || cmd.walk_next)
        begin
            nk_rdata <= nk_mem[node_raddr];
            nv_rdata <= nv_mem[node_raddr];
            nn_rdata <= nn_mem[node_raddr];
        end
    end

    // bucket head writes
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step && (int'(clr_reg) < MAX_BUCKETS))
        begin
            bh_mem[clr_reg[BW-1:0]] <= NO_NODE;
        end
        else if (cmd.insert)
        begin
            bh_mem[bkt_reg] <= {1'b0, fs_rdata};
        end
        else if (cmd.unlink && (prev_reg == NO_NODE))
        begin
            bh_mem[bkt_reg] <= nn_rdata;
        end
    end

    // free stack writes
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step && (int'(clr_reg) < NODE_POOL))
        begin
            fs_mem[clr_reg[NIW-1:0]] <= clr_reg[NIW-1:0];
        end
        else if (cmd.unlink)
        begin
            fs_mem[free_count_reg[NIW-1:0]] <= cur_reg[NIW-1:0];
        end
    end

    // node writes
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            nk_mem[fs_rdata] <= key_reg;
            nv_mem[fs_rdata] <= value_reg;
            nn_mem[fs_rdata] <= bh_rdata;
        end
        else if (cmd.unlink && (prev_reg != NO_NODE))
        begin
            nn_mem[prev_reg[NIW-1:0]] <= nn_rdata;
        end
    end

    // request and walk payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_type_reg <= req.req_type;
            key_reg      <= req.key;
            value_reg    <= req.value;
            bkt_reg      <= bkt_in;
        end
        if (cmd.walk_head)
        begin
            cur_reg  <= bh_rdata;
            prev_reg <= NO_NODE;
        end
        else if (cmd.walk_next)
        begin
            cur_reg  <= nn_rdata;
            prev_reg <= cur_reg;
        end
        if (cmd.set_res)
        begin
            res_status_reg <= cmd.res_status;
            res_value_reg  <= cmd.res_found ? nv_rdata : '0;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_count_reg  <= stored_reg;
        end
    end

    // register, counters and clearing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg       <= BITS_MIN;
            clr_reg        <= '0;
            free_count_reg <= POOL_CNT;
            stored_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            bits_reg       <= bits_in;
            clr_reg        <= '0;
            free_count_reg <= POOL_CNT;
            stored_reg     <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + CLRW'(1);
            end
            if (cmd.insert)
            begin
                free_count_reg <= free_count_reg - CNTW'(1);
                stored_reg     <= stored_reg + CNTW'(1);
            end
            else if (cmd.unlink)
            begin
                free_count_reg <= free_count_reg + CNTW'(1);
                stored_reg     <= stored_reg - CNTW'(1);
            end
        end
    end

    // result beat holding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // ports
    assign req.ready       = cmd.idle;
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.found_value = out_value_reg;
    assign rsp.entry_count = out_count_reg;

    // status to controller
    assign sts.in_valid   = req.valid;
    assign sts.cfg_wr     = cfg.valid;
    assign sts.req_type   = req_type_reg;
    assign sts.pool_empty = (free_count_reg == '0);
    assign sts.head_empty = (bh_rdata == NO_NODE);
    assign sts.key_match  = (nk_rdata == key_reg);
    assign sts.next_empty = (nn_rdata == NO_NODE);
    assign sts.clr_last   = (clr_reg == CLRW'(CLR_N - 1));
    assign sts.out_busy   = out_valid_reg && !rsp.ready;

endmodule

// ===== hw/rtl/chained_hash_table.sv =====
// ----------------------------------------------------------------------------
// chained_hash_table
// Key/value store with separate chaining over a fixed node pool.
// ----------------------------------------------------------------------------
// One request is handled at a time. An insert, or a delete or lookup that
// finds its bucket empty, gets its result without walking the chain; a
// delete or lookup that finds a chain walks it, reading one node per cycle
// from the node store, until a key match or the end of the chain. The next
// request can be accepted in the cycle after the result is loaded. A
// finished result sits in an output register so the next request can be
// accepted while it waits; if that register still holds an untaken beat,
// the new result waits for it and requests are held off. After reset and
// after every bucket_bits write a clearing sweep rebuilds the bucket heads
// and free stack; requests are held off meanwhile.
module chained_hash_table #(
    parameter int MAX_BUCKETS = 256,
    parameter int NODE_POOL   = 256,
    parameter int KEY_WIDTH   = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    cht_req_if.sink   req,
    cht_rsp_if.source rsp,
    cht_cfg_if.sink   cfg
);
    import cht_pkg::*;

    cht_cmd_t cmd;
    cht_sts_t sts;

    // sequencer
    cht_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // storage and counters
    cht_dpath #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .NODE_POOL   (NODE_POOL),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg),
        .cmd   (cmd),
        .sts   (sts)
    );

endmodule
